// File: sv/dzt_pkg.sv
// Shared constants, tables and types of the 8x8 DCT / zigzag truncation / IDCT block.
// Used by dzt_mac, dct8x8_zigzag_truncate_idct, its checker and its testbench; depends on nothing else.
package dzt_pkg;

  localparam int BLOCK_COUNT = 4096;
  localparam int PIX_W       = 8;
  localparam int COEF_W      = 16;
  localparam int BUDGET_W    = 19;
  localparam int KEEP_W      = 7;
  localparam int OPND_W      = 33;
  localparam int ACC_W       = 51;
  localparam int DIGIT_W     = 4;
  localparam int BMAG_W      = 16;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 19'd262144;

  // Q1.14 basis T[u][x], indexed u*8+x.
  localparam logic signed [14:0] BASIS_TBL [64] = '{
    15'sd5793,  15'sd5793,  15'sd5793,  15'sd5793,
    15'sd5793,  15'sd5793,  15'sd5793,  15'sd5793,
    15'sd8035,  15'sd6811,  15'sd4551,  15'sd1598,
    -15'sd1598, -15'sd4551, -15'sd6811, -15'sd8035,
    15'sd7568,  15'sd3135,  -15'sd3135, -15'sd7568,
    -15'sd7568, -15'sd3135, 15'sd3135,  15'sd7568,
    15'sd6811,  -15'sd1598, -15'sd8035, -15'sd4551,
    15'sd4551,  15'sd8035,  15'sd1598,  -15'sd6811,
    15'sd5793,  -15'sd5793, -15'sd5793, 15'sd5793,
    15'sd5793,  -15'sd5793, -15'sd5793, 15'sd5793,
    15'sd4551,  -15'sd8035, 15'sd1598,  15'sd6811,
    -15'sd6811, -15'sd1598, 15'sd8035,  -15'sd4551,
    15'sd3135,  -15'sd7568, 15'sd7568,  -15'sd3135,
    -15'sd3135, 15'sd7568,  -15'sd7568, 15'sd3135,
    15'sd1598,  -15'sd4551, 15'sd6811,  -15'sd8035,
    15'sd8035,  -15'sd6811, 15'sd4551,  -15'sd1598
  };

  // Zigzag rank of coefficient (u,v), indexed u*8+v.
  localparam logic [5:0] ZZ_RANK [64] = '{
    6'd0,  6'd1,  6'd5,  6'd6,  6'd14, 6'd15, 6'd27, 6'd28,
    6'd2,  6'd4,  6'd7,  6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
    6'd3,  6'd8,  6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
    6'd9,  6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
    6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
    6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
    6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
    6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63
  };

  typedef struct packed {
    logic               step;
    logic               clear;
    logic               neg;
    logic [DIGIT_W-1:0] digit;
    logic [1:0]         dsel;
  } mac_ctl_t;

endpackage

// File: sv/dzt_mac.sv
// Digit-serial multiply-accumulate unit: one 4-bit digit of the basis magnitude per cycle while step is high.
// Depends on dzt_pkg.
module dzt_mac (
  input  logic                                clk,
  input  dzt_pkg::mac_ctl_t                   ctl,
  input  logic signed [dzt_pkg::OPND_W-1:0]   opnd,
  output logic signed [dzt_pkg::ACC_W-1:0]    acc
);
  import dzt_pkg::*;

  logic signed [ACC_W-1:0]          acc_r;
  logic signed [ACC_W-1:0]          acc_nxt;
  logic signed [OPND_W+DIGIT_W:0]   prod;
  logic signed [ACC_W-1:0]          prod_ext;
  logic signed [ACC_W-1:0]          shifted;
  logic signed [ACC_W-1:0]          base;

  always_comb begin
    prod     = opnd * $signed({1'b0, ctl.digit});
    prod_ext = ACC_W'(prod);
    case (ctl.dsel)
      2'd0:    shifted = prod_ext;
      2'd1:    shifted = prod_ext <<< 4;
      2'd2:    shifted = prod_ext <<< 8;
      2'd3:    shifted = prod_ext <<< 12;
      default: shifted = prod_ext;
    endcase
    base    = ctl.clear ? '0 : acc_r;
    acc_nxt = ctl.neg ? base - shifted : base + shifted;
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: sv/dct8x8_zigzag_truncate_idct.sv
// Top level: pixel, coefficient and transpose stores, pass sequencer and result stage.
// Depends on dzt_pkg and dzt_mac.
//
// A block is 64 pixels taken one per cycle while busy is low. The 64th pixel raises
// busy, and the block then runs four separable passes (row DCT, column DCT with
// rounding and saturation, masked row IDCT, column IDCT) on one digit-serial MAC:
// 64 sums of 8 products per pass, each product one store read step and then one MAC
// step per 4-bit digit of the basis magnitude, and a flush state ends the block; no
// new pixel is taken until then. The 64 reconstructed pixels come out in the last pass,
// the final one after the flush state, each on out_valid for a single cycle; the
// receiver cannot stall them. The kept coefficient count is taken from the budget
// register when the 64th pixel arrives.
module dct8x8_zigzag_truncate_idct (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [dzt_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                            out_valid,
  output logic [dzt_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                            out_block_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dzt_pkg::BUDGET_W-1:0]    cfg_coefficient_budget
);
  import dzt_pkg::*;

  typedef enum logic [2:0] {S_LOAD, S_F1, S_F2, S_I1, S_I2, S_FLUSH} state_t;

  state_t state_r, state_nxt, wr_st_r, wr_st_nxt;
  logic [5:0] load_cnt_r, load_cnt_nxt;
  logic [5:0] o_r, o_nxt, wr_o_r, wr_o_nxt;
  logic [2:0] k_r, k_nxt, ph_r, ph_nxt;
  logic       wr_pend_r, wr_pend_nxt;
  logic [KEEP_W-1:0] keep_r, keep_nxt;
  logic [BUDGET_W-1:0] budget_r;
  logic       out_valid_r, out_valid_nxt, out_end_r, out_end_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;

  logic [PIX_W-1:0]         pix_mem  [64];
  logic signed [COEF_W-1:0] coef_mem [64];
  logic signed [OPND_W-1:0] tmp_mem  [64];
  logic [PIX_W-1:0]         pix_rd_r;
  logic signed [COEF_W-1:0] coef_rd_r;
  logic signed [OPND_W-1:0] tmp_rd_r;
  logic                     mask_r;

  logic                     accept, compute;
  logic [5:0]               rd_addr, b_idx;
  logic signed [14:0]       bval;
  logic [BMAG_W-1:0]        bmag;
  logic signed [OPND_W-1:0] opnd;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd, q;
  logic signed [COEF_W-1:0] coef_wr;
  logic [BUDGET_W:0]        keep_sum, keep_quo;
  mac_ctl_t                 ctl;

  assign accept    = start && !busy;
  assign compute   = (state_r == S_F1) || (state_r == S_F2) ||
                     (state_r == S_I1) || (state_r == S_I2);
  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      budget_r <= cfg_coefficient_budget;
    end
  end

  assign keep_sum = {1'b0, budget_r} + (BUDGET_W+1)'(BLOCK_COUNT / 2);
  assign keep_quo = (BUDGET_W+1)'(keep_sum / BLOCK_COUNT);

  // Row-major passes read along a row of the source; column passes read down a column.
  always_comb begin
    if (state_r == S_F1 || state_r == S_I1) begin
      rd_addr = {o_r[5:3], k_r};
    end else begin
      rd_addr = {k_r, o_r[2:0]};
    end
    case (state_r)
      S_F1:    b_idx = {o_r[2:0], k_r};
      S_F2:    b_idx = {o_r[5:3], k_r};
      S_I1:    b_idx = {k_r, o_r[2:0]};
      S_I2:    b_idx = {k_r, o_r[5:3]};
      default: b_idx = '0;
    endcase
    bval = BASIS_TBL[b_idx];
    bmag = bval[14] ? BMAG_W'(-bval) : BMAG_W'(bval);
    case (state_r)
      S_F1:       opnd = OPND_W'({1'b0, pix_rd_r});
      S_I1:       opnd = mask_r ? OPND_W'(coef_rd_r) : '0;
      S_F2, S_I2: opnd = tmp_rd_r;
      default:    opnd = '0;
    endcase
    ctl.step  = compute && (ph_r != 3'd0);
    ctl.clear = (k_r == 3'd0) && (ph_r == 3'd1);
    ctl.neg   = bval[14];
    ctl.dsel  = 2'(ph_r - 3'd1);
    ctl.digit = bmag[{ctl.dsel, 2'b00} +: DIGIT_W];
  end

  dzt_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .opnd (opnd),
    .acc  (acc)
  );

  // Round half away from zero to 3 fraction bits, then saturate to 16 bits.
  always_comb begin
    rnd = acc + ACC_W'(33'sd16777216) - ACC_W'({1'b0, acc[ACC_W-1]});
    q   = rnd >>> 25;
    if (q > ACC_W'(32767)) begin
      coef_wr = 16'sh7FFF;
    end else if (q < -ACC_W'(32768)) begin
      coef_wr = -16'sh8000;
    end else begin
      coef_wr = COEF_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_mem[load_cnt_r] <= in_pixel_in;
    end
    if (wr_pend_r && wr_st_r == S_F2) begin
      coef_mem[wr_o_r] <= coef_wr;
    end
    if (wr_pend_r && (wr_st_r == S_F1 || wr_st_r == S_I1)) begin
      tmp_mem[wr_o_r] <= OPND_W'(acc);
    end
    if (ph_r == 3'd0) begin
      pix_rd_r  <= pix_mem[rd_addr];
      coef_rd_r <= coef_mem[rd_addr];
      tmp_rd_r  <= tmp_mem[rd_addr];
      mask_r    <= {1'b0, ZZ_RANK[rd_addr]} < keep_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    o_nxt         = o_r;
    k_nxt         = k_r;
    ph_nxt        = ph_r;
    keep_nxt      = keep_r;
    wr_pend_nxt   = compute && (ph_r == 3'd4) && (k_r == 3'd7);
    wr_st_nxt     = wr_pend_nxt ? state_r : wr_st_r;
    wr_o_nxt      = wr_pend_nxt ? o_r : wr_o_r;
    out_valid_nxt = wr_pend_r && (wr_st_r == S_I2);
    out_end_nxt   = out_valid_nxt && (wr_o_r == 6'd63);
    if (acc[ACC_W-1] || acc == '0) begin
      out_pix_nxt = '0;
    end else if (|acc[ACC_W-1:39]) begin
      out_pix_nxt = 8'd255;
    end else begin
      out_pix_nxt = acc[38:31];
    end
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          load_cnt_nxt = load_cnt_r + 6'd1;
          if (load_cnt_r == 6'd63) begin
            state_nxt = S_F1;
            keep_nxt  = (keep_quo > (BUDGET_W+1)'(64)) ? KEEP_W'(64) : keep_quo[KEEP_W-1:0];
          end
        end
      end
      S_F1, S_F2, S_I1, S_I2: begin
        if (ph_r == 3'd4) begin
          ph_nxt = 3'd0;
          k_nxt  = k_r + 3'd1;
          if (k_r == 3'd7) begin
            o_nxt = o_r + 6'd1;
            if (o_r == 6'd63) begin
              case (state_r)
                S_F1:    state_nxt = S_F2;
                S_F2:    state_nxt = S_I1;
                S_I1:    state_nxt = S_I2;
                default: state_nxt = S_FLUSH;
              endcase
            end
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_FLUSH: state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      o_r         <= '0;
      k_r         <= '0;
      ph_r        <= '0;
      wr_pend_r   <= 1'b0;
      wr_st_r     <= S_LOAD;
      wr_o_r      <= '0;
      keep_r      <= '0;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      o_r         <= o_nxt;
      k_r         <= k_nxt;
      ph_r        <= ph_nxt;
      wr_pend_r   <= wr_pend_nxt;
      wr_st_r     <= wr_st_nxt;
      wr_o_r      <= wr_o_nxt;
      keep_r      <= keep_nxt;
      out_valid_r <= out_valid_nxt;
      out_end_r   <= out_end_nxt;
    end
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_block_end = out_end_r;

`ifndef ASSERT_OFF
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (ph_r == 3'd0 && k_r == 3'd0 && o_r == 6'd0))
    else $error("sequencer counters not cleared while idle");
  a_wr_on_phase0: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (ph_r == 3'd0))
    else $error("result write outside the read phase");
  a_out_from_i2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(wr_pend_r && wr_st_r == S_I2))
    else $error("output beat without a finished inverse column sum");
  a_end_follows_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_r |-> $past(state_r == S_FLUSH))
    else $error("block end not aligned with the flush cycle");
`endif

endmodule

// File: dv/dct8x8_zigzag_truncate_idct_check.sv
// Checker for the 8x8 DCT / zigzag truncation / IDCT block: it watches the pixel, result
// and budget channels, predicts each reconstructed block and compares it beat by beat.
// Depends on dzt_pkg for widths, the basis table and the zigzag ranks.
`timescale 1ns / 1ps

module dct8x8_zigzag_truncate_idct_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [dzt_pkg::PIX_W-1:0]    in_pixel_in,
  input  logic                         out_valid,
  input  logic [dzt_pkg::PIX_W-1:0]    out_pixel_out,
  input  logic                         out_block_end,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [dzt_pkg::BUDGET_W-1:0] cfg_coefficient_budget,
  output int                           errors,
  output int                           pending
);
  import dzt_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             block_end;
  } recon_t;

  recon_t                   recon_q[$];
  logic [PIX_W-1:0]         pixels[64];
  logic signed [COEF_W-1:0] coeffs[64];
  logic [BUDGET_W-1:0]      budget;
  int                       fill_count;
  int                       blocks_seen;

  function automatic longint tbl(int row, int col);
    return longint'(BASIS_TBL[row*8+col]);
  endfunction

  // Forward transform, coefficient masking and inverse transform of the stored block.
  task automatic reconstruct_block();
    longint acc, mag, q, keep;
    recon_t r;
    keep = (longint'(budget) + BLOCK_COUNT / 2) / BLOCK_COUNT;
    if (keep > 64) keep = 64;
    for (int u = 0; u < 8; u++)
      for (int v = 0; v < 8; v++) begin
        acc = 0;
        for (int x = 0; x < 8; x++)
          for (int y = 0; y < 8; y++)
            acc += longint'(pixels[x*8+y]) * tbl(u, x) * tbl(v, y);
        // Round half away from zero to three fraction bits.
        mag = (acc < 0) ? -acc : acc;
        q = (mag + (64'sd1 <<< 24)) >>> 25;
        if (acc < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        coeffs[u*8+v] = q[COEF_W-1:0];
      end
    for (int i = 0; i < 64; i++) begin
      acc = 0;
      for (int u = 0; u < 8; u++)
        for (int v = 0; v < 8; v++)
          if (longint'(ZZ_RANK[u*8+v]) < keep)
            acc += longint'(coeffs[u*8+v]) * tbl(u, i / 8) * tbl(v, i % 8);
      if (acc <= 0) q = 0;
      else begin
        q = acc >>> 31;
        if (q > 255) q = 255;
      end
      r.pixel = q[PIX_W-1:0];
      r.block_end = (i == 63);
      recon_q.push_back(r);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    fill_count = 0;
    blocks_seen = 0;
    budget = BUDGET_RESET;
  end

  always @(posedge clk) begin
    recon_t want;
    if (!rst_n) begin
      fill_count = 0;
      budget = BUDGET_RESET;
    end else begin
      if (cfg_valid && cfg_ready) budget = cfg_coefficient_budget;
      if (start && !busy) begin
        pixels[fill_count] = in_pixel_in;
        fill_count++;
        if (fill_count == 64) begin
          fill_count = 0;
          blocks_seen++;
          reconstruct_block();
        end
      end
      if (out_valid) begin
        if (recon_q.size() == 0) begin
          $display("%0t: unexpected result beat pixel=%0d block_end=%0b", $time,
                   out_pixel_out, out_block_end);
          errors++;
        end else begin
          want = recon_q.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel,
                     out_pixel_out);
            errors++;
          end
          if (out_block_end !== want.block_end) begin
            $display("%0t: block_end expected %0b actual %0b", $time, want.block_end,
                     out_block_end);
            errors++;
          end
        end
      end
    end
    pending = recon_q.size();
  end

endmodule

// File: dv/dct8x8_zigzag_truncate_idct_test.sv
// Testbench top for the 8x8 DCT / zigzag truncation / IDCT block: pixel and budget
// stimulus, clock, reset and verdict. Depends on dzt_pkg, the block and its checker.
`timescale 1ns / 1ps

module dct8x8_zigzag_truncate_idct_test;
  import dzt_pkg::*;

  localparam int NUM_BLOCKS = 6;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [PIX_W-1:0]    in_pixel_in;
  logic                out_valid;
  logic [PIX_W-1:0]    out_pixel_out;
  logic                out_block_end;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BUDGET_W-1:0] cfg_coefficient_budget;
  int                  errors;
  int                  pending;
  bit                  gaps_on;

  dct8x8_zigzag_truncate_idct u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_pixel_in            (in_pixel_in),
    .out_valid              (out_valid),
    .out_pixel_out          (out_pixel_out),
    .out_block_end          (out_block_end),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_coefficient_budget (cfg_coefficient_budget)
  );

  dct8x8_zigzag_truncate_idct_check u_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_pixel_in            (in_pixel_in),
    .out_valid              (out_valid),
    .out_pixel_out          (out_pixel_out),
    .out_block_end          (out_block_end),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_coefficient_budget (cfg_coefficient_budget),
    .errors                 (errors),
    .pending                (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // One pixel beat; start stays high across back-to-back beats.
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_in <= p;
    do @(posedge clk); while (busy);
  endtask

  // Budget writes happen only with the block drained and idle.
  task automatic write_budget(input logic [BUDGET_W-1:0] b);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_coefficient_budget <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PIX_W-1:0]    corner_px[16];
    logic [BUDGET_W-1:0] budget_plan[NUM_BLOCKS];
    int                  mode, base;
    corner_px = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd1, 8'd128, 8'd254, 8'd127,
                  8'd255, 8'd255, 8'd0, 8'd0, 8'h0F, 8'hF0, 8'd255, 8'd0};
    // Reset value, no coefficients kept, one kept, a random count, saturated, random.
    budget_plan = '{BUDGET_RESET, 19'd2047, 19'd2048, 19'd0, 19'h7FFFF, 19'd0};
    budget_plan[3] = BUDGET_W'($urandom_range(4096, 258047));
    budget_plan[5] = BUDGET_W'($urandom_range(0, 262144));

    rst_n = 1'b0;
    start = 1'b0;
    in_pixel_in = '0;
    cfg_valid = 1'b0;
    cfg_coefficient_budget = '0;
    gaps_on = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      if (blk > 0) write_budget(budget_plan[blk]);
      gaps_on = ($urandom_range(0, 2) != 0);
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 255);
      for (int i = 0; i < 64; i++) begin
        if (blk == 0 && i < 16) send_pixel(corner_px[i]);
        else if (mode == 0) send_pixel(PIX_W'($urandom_range(0, 255)));
        // A smooth ramp keeps energy in the low-order coefficients.
        else if (mode == 1) send_pixel(PIX_W'((base + 3 * (i / 8) + 2 * (i % 8)) % 256));
        else send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
      end
    end
    start <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d blocks of 64 pixels over budgets from none kept to all kept,",
             NUM_BLOCKS);
    $display("with corner-value, ramp, random and full-swing pixel content.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
